// File: rtl/trial_division_prime_test_core_assert.svh
// assertion macros for the trial division prime tester
`ifndef TRIAL_DIVISION_PRIME_TEST_CORE_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TDPT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tdpt assertion failed");
`define TDPT_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("tdpt assertion failed");
`else
`define TDPT_ASSERT(lbl, prop)
`define TDPT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: rtl/tdpt_pkg.sv
package tdpt_pkg;

	localparam int FIELD_BITS = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_OUT
	} state_t;

endpackage

// File: rtl/trial_division_prime_test_core.sv
// trial division prime tester
// candidate channel: candidate with cand_valid / cand_ready; one number per transaction.
// result channel: tested_value and is_prime with res_valid / res_ready; exactly one
// result transaction per candidate, in order.
// numbers below 2 are not prime; otherwise divisors d = 2, 3, ... are tried while
// d <= x / d, and the first zero remainder ends the search as not prime.
// one shared restoring divider gives quotient and remainder of x / d one quotient bit
// per divide step (VALUE_BITS bits, at most 32), and a compare step follows each divisor.
// values below 2 go straight to the output state; others run the divider for each
// divisor tried, up to 65535 divisors for 32-bit primes. one candidate is worked on
// at a time; cand_ready is high only while the divider is free, from the cycle after
// the result is loaded, so no new candidate is taken before the last one is through.
// with VALUE_BITS below 32 only the low VALUE_BITS bits of the candidate are tested
// and echoed.
// the result sits in an output register; while the receiver stalls it holds, and a
// new candidate is still taken. a finished test waits for that register to empty.
// reset (arst_n low, asynchronous) clears the sequencer and the result valid.
`include "trial_division_prime_test_core_assert.svh"

module trial_division_prime_test_core #(
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] candidate,
	input  logic        cand_valid,
	output logic        cand_ready,
	output logic [31:0] tested_value,
	output logic        is_prime,
	output logic        res_valid,
	input  logic        res_ready
);

	localparam int XW = (VALUE_BITS < tdpt_pkg::FIELD_BITS) ? VALUE_BITS : tdpt_pkg::FIELD_BITS;
	localparam int CW = $clog2(XW);

	tdpt_pkg::state_t state_q, state_d;

	logic [XW-1:0] x_in;
	logic [XW-1:0] x_q;
	logic [XW-1:0] d_q;
	logic [XW-1:0] rem_q;
	logic [XW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          prime_q;

	logic [XW:0]   trial;
	logic [XW-1:0] diff;
	logic          fits;
	logic          out_free;
	logic          load_res;
	logic          accept;
	logic          below_two;

	logic          res_valid_q;
	logic [31:0]   tested_value_q;
	logic          is_prime_q;

	assign x_in      = candidate[XW-1:0];
	assign below_two = (x_in < XW'(2));
	assign accept    = cand_valid && cand_ready;
	assign out_free  = !res_valid_q || res_ready;

	// one restoring divide step
	assign trial = {rem_q, quo_q[XW-1]};
	assign diff  = trial[XW-1:0] - d_q;
	assign fits  = (trial >= {1'b0, d_q});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tdpt_pkg::ST_IDLE: begin
				if (cand_valid) begin
					state_d = below_two ? tdpt_pkg::ST_OUT : tdpt_pkg::ST_DIV;
				end
			end
			tdpt_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = tdpt_pkg::ST_CHECK;
				end
			end
			tdpt_pkg::ST_CHECK: begin
				// quotient below divisor means no divisor up to the square root
				if ((quo_q < d_q) || (rem_q == '0)) begin
					state_d = tdpt_pkg::ST_OUT;
				end else begin
					state_d = tdpt_pkg::ST_DIV;
				end
			end
			tdpt_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = tdpt_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		cand_ready = 1'b0;
		load_res   = 1'b0;
		unique case (state_q)
			tdpt_pkg::ST_IDLE:  cand_ready = 1'b1;
			tdpt_pkg::ST_DIV:   ;
			tdpt_pkg::ST_CHECK: ;
			tdpt_pkg::ST_OUT:   load_res = out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tdpt_pkg::ST_IDLE: begin
				if (accept) begin
					x_q     <= x_in;
					d_q     <= XW'(2);
					rem_q   <= '0;
					quo_q   <= x_in;
					cnt_q   <= CW'(XW - 1);
					prime_q <= 1'b0;
				end
			end
			tdpt_pkg::ST_DIV: begin
				rem_q <= fits ? diff : trial[XW-1:0];
				quo_q <= {quo_q[XW-2:0], fits};
				cnt_q <= cnt_q - CW'(1);
			end
			tdpt_pkg::ST_CHECK: begin
				prime_q <= (quo_q < d_q);
				d_q     <= d_q + XW'(1);
				rem_q   <= '0;
				quo_q   <= x_q;
				cnt_q   <= CW'(XW - 1);
			end
			tdpt_pkg::ST_OUT: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			tested_value_q <= 32'(x_q);
			is_prime_q     <= prime_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign tested_value = tested_value_q;
	assign is_prime     = is_prime_q;

	// divider keeps the partial remainder below the divisor
	`TDPT_ASSERT(a_rem_below_div, (state_q == tdpt_pkg::ST_CHECK) |-> (rem_q < d_q))
	// trial divisors start at two
	`TDPT_ASSERT(a_div_from_two, (state_q == tdpt_pkg::ST_DIV) |-> (d_q >= XW'(2)))
	// the only even prime is two, so zero is never reported prime
	`TDPT_ASSERT(a_even_prime, (res_valid && is_prime) |-> (tested_value[0] || (tested_value == 32'd2)))
	`TDPT_ASSERT_ALWAYS(a_rst_no_result, (!arst_n) |-> (!res_valid))

endmodule

// File: sim/trial_division_prime_test_core_tb.sv
module trial_division_prime_test_core_tb;

	localparam int CLK_PERIOD = 12;
	localparam int DUT_VALUE_BITS = 32;
	localparam int FB = tdpt_pkg::FIELD_BITS;
	localparam logic [FB-1:0] VALUE_MASK = (DUT_VALUE_BITS >= FB) ? '1 :
		((FB'(1) << DUT_VALUE_BITS) - FB'(1));
	// random candidates are redrawn if trial division examines more than this many divisors
	localparam int unsigned LARGE_TRY_CAP = 300;
	localparam int unsigned PRESSURE_HOLD_CYCLES = 600;
	localparam int unsigned END_TAIL_CYCLES = 40;
	localparam longint unsigned TIMEOUT_CYCLES = 20_000_000;

	typedef struct {
		logic [FB-1:0] value;
		bit            prime;
	} verdict_t;

	logic          clk;
	logic          arst_n;
	logic [FB-1:0] candidate;
	logic          cand_valid;
	logic          cand_ready;
	logic [FB-1:0] tested_value;
	logic          is_prime;
	logic          res_valid;
	logic          res_ready;

	verdict_t    awaited_verdicts[$];
	int unsigned mismatches;
	int unsigned hold_request;
	bit          no_gaps;

	trial_division_prime_test_core #(
		.VALUE_BITS(DUT_VALUE_BITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.candidate   (candidate),
		.cand_valid  (cand_valid),
		.cand_ready  (cand_ready),
		.tested_value(tested_value),
		.is_prime    (is_prime),
		.res_valid   (res_valid),
		.res_ready   (res_ready)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Regression FAIL");
		$finish;
	end

	// primality by trial division; tries counts the divisors examined
	function automatic bit trial_verdict(input logic [FB-1:0] x, output int unsigned tries);
		logic [63:0] n;
		logic [63:0] d;
		tries = 0;
		n = 64'(x & VALUE_MASK);
		if (n < 64'd2)
			return 1'b0;
		for (d = 64'd2; d <= n / d; d++) begin
			tries++;
			if (n % d == 64'd0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// mostly none, often short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic offer_candidate(input logic [FB-1:0] x);
		int unsigned gap;
		int unsigned tries;
		verdict_t    v;
		gap = no_gaps ? 0 : pick_gap();
		if (gap != 0) begin
			cand_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		candidate <= x;
		cand_valid <= 1'b1;
		do @(posedge clk); while (!cand_ready);
		v.value = x & VALUE_MASK;
		v.prime = trial_verdict(x, tries);
		awaited_verdicts.push_back(v);
	endtask

	task automatic settle();
		cand_valid <= 1'b0;
		@(posedge clk);
		while (awaited_verdicts.size() != 0) @(posedge clk);
	endtask

	// result side: random stalls, plus a long hold when a test asks for one
	initial begin
		int unsigned idle_left;
		idle_left = 0;
		res_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				idle_left = hold_request;
				hold_request = 0;
			end else if (idle_left == 0 && !no_gaps) begin
				idle_left = pick_gap();
			end
			if (idle_left != 0) begin
				idle_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && res_valid && res_ready) begin
			if (awaited_verdicts.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual value %0h prime %0b",
					$time, tested_value, is_prime);
				mismatches++;
			end else begin
				v = awaited_verdicts.pop_front();
				if (tested_value !== v.value) begin
					$display("%0t: tested_value mismatch, expected %0h, actual %0h",
						$time, v.value, tested_value);
					mismatches++;
				end
				if (is_prime !== v.prime) begin
					$display("%0t: is_prime mismatch for %0d, expected %0b, actual %0b",
						$time, v.value, v.prime, is_prime);
					mismatches++;
				end
			end
		end
	end

	task automatic test_below_two();
		offer_candidate(32'd0);
		offer_candidate(32'd1);
		settle();
	endtask

	// two and three end at the first divisor; four is the first square
	task automatic test_small_values();
		offer_candidate(32'd2);
		offer_candidate(32'd3);
		offer_candidate(32'd4);
		offer_candidate(32'd5);
		offer_candidate(32'd7);
		offer_candidate(32'd9);
		offer_candidate(32'd25);
		offer_candidate(32'd49);
		settle();
	endtask

	task automatic test_field_extremes();
		offer_candidate(32'hFFFF_FFFF);
		offer_candidate(32'hFFFF_FFFE);
		offer_candidate(32'h8000_0000);
		offer_candidate(32'hAAAA_AAAA);
		offer_candidate(32'h5555_5555);
		settle();
	endtask

	// divisor bound reached exactly, and primes that run the loop to the end
	task automatic test_square_bound();
		offer_candidate(32'd1018081);
		offer_candidate(32'd1018080);
		offer_candidate(32'd1022117);
		offer_candidate(32'd65521);
		offer_candidate(32'd1048573);
		settle();
	endtask

	// receiver holds off long enough for the block to back up its input
	task automatic test_backpressure();
		no_gaps = 1'b1;
		hold_request = PRESSURE_HOLD_CYCLES;
		repeat (8) offer_candidate($urandom_range(0, 50));
		settle();
		no_gaps = 1'b0;
	endtask

	task automatic test_random_mix(input int unsigned count);
		logic [FB-1:0] x;
		int unsigned   tries;
		int unsigned   kind;
		for (int unsigned i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			do begin
				if (kind < 5)
					x = $urandom_range(0, 4095);
				else if (kind < 7)
					x = $urandom_range(0, 65535);
				else
					x = $urandom();
				void'(trial_verdict(x, tries));
			end while (tries > LARGE_TRY_CAP);
			offer_candidate(x);
		end
		settle();
	endtask

	task automatic test_back_to_back(input int unsigned count);
		no_gaps = 1'b1;
		test_random_mix(count);
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b1;
		candidate = '0;
		cand_valid = 1'b0;
		mismatches = 0;
		hold_request = 0;
		no_gaps = 1'b0;
		// reset goes low after time zero so its falling edge is always seen
		#(CLK_PERIOD / 4);
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_below_two();
		test_small_values();
		test_field_extremes();
		test_square_bound();
		test_backpressure();
		test_random_mix(60);
		test_back_to_back(20);

		repeat (END_TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
